// ===== rtl/core/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  // Result classification, as seen on root_status_o
  typedef enum logic [1:0] {
    ST_TWO_ROOTS = 2'd0,
    ST_LINEAR    = 2'd1,
    ST_INDET     = 2'd2,
    ST_COMPLEX   = 2'd3
  } status_e;

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Two roots are divided side by side
  localparam int unsigned NUM_LANES = 2;

endpackage

`default_nettype wire

// ===== rtl/core/qrs_front.sv =====
// ----------------------------------------------------------------------------
// qrs_front
// Accepts coefficient sets, forms b^2 and 4ac, classifies the equation and
// hands discriminant, numerator base and divisor to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_front import qrs_pkg::*; #(
  parameter int unsigned COEF_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic signed [COEF_WIDTH-1:0]           coef_a_i,
  input  logic signed [COEF_WIDTH-1:0]           coef_b_i,
  input  logic signed [COEF_WIDTH-1:0]           coef_c_i,
  output logic                                   q_push_o,
  input  logic                                   q_full_i,
  output status_e                                status_o,
  output logic signed [COEF_WIDTH+FRAC_BITS:0]   base_o,
  output logic signed [COEF_WIDTH:0]             den_o,
  output logic        [2*COEF_WIDTH:0]           disc_o
);

  localparam int unsigned W     = COEF_WIDTH;
  localparam int unsigned BASEW = COEF_WIDTH + FRAC_BITS + 1;
  localparam int unsigned DENW  = COEF_WIDTH + 1;
  localparam int unsigned DISCW = 2 * COEF_WIDTH + 1;
  localparam int unsigned EXTW  = 2 * COEF_WIDTH + 2;

  logic                    adv;
  logic                    accept;
  logic                    s1_load;
  logic                    a_zero;
  logic                    b_zero;
  logic [W-1:0]            mag_a_d;
  logic [W-1:0]            mag_b_d;
  logic [W-1:0]            mag_c_d;
  logic signed [W-1:0]     neg_src;
  logic signed [BASEW-1:0] src_ext;
  logic signed [BASEW-1:0] base_d;
  logic signed [DENW-1:0]  den_d;
  status_e                 sts_d;

  logic                    s1_v_q;
  logic [W-1:0]            mag_a_q;
  logic [W-1:0]            mag_b_q;
  logic [W-1:0]            mag_c_q;
  logic                    sgn_diff1_q;
  status_e                 sts1_q;
  logic signed [BASEW-1:0] base1_q;
  logic signed [DENW-1:0]  den1_q;

  logic                    s2_v_q;
  logic [2*W-1:0]          bsq_q;
  logic [2*W-1:0]          ac_q;
  logic                    sgn_diff2_q;
  status_e                 sts2_q;
  logic signed [BASEW-1:0] base2_q;
  logic signed [DENW-1:0]  den2_q;

  logic [EXTW-1:0]         bsq_x;
  logic [EXTW-1:0]         ac4_x;
  logic [EXTW-1:0]         disc_x;

  // Handshake: both stages move together when the last one can drain
  assign adv      = !s2_v_q || !q_full_i;
  assign q_push_o = s2_v_q && !q_full_i;
  assign full_o   = s1_v_q && !adv;
  assign accept   = push_i && !full_o;
  assign s1_load  = !s1_v_q || adv;

  // Stage 1 inputs: magnitudes, numerator base and divisor for either case
  always_comb begin
    a_zero  = (coef_a_i == '0);
    b_zero  = (coef_b_i == '0);
    mag_a_d = coef_a_i[W-1] ? W'(-$unsigned(coef_a_i)) : $unsigned(coef_a_i);
    mag_b_d = coef_b_i[W-1] ? W'(-$unsigned(coef_b_i)) : $unsigned(coef_b_i);
    mag_c_d = coef_c_i[W-1] ? W'(-$unsigned(coef_c_i)) : $unsigned(coef_c_i);
    neg_src = a_zero ? coef_c_i : coef_b_i;
    src_ext = BASEW'(neg_src);
    base_d  = (BASEW'(0) - src_ext) <<< FRAC_BITS;
    den_d   = a_zero ? DENW'(coef_b_i) : (DENW'(coef_a_i) <<< 1);
    if (a_zero && b_zero) begin
      sts_d = ST_INDET;
    end else if (a_zero) begin
      sts_d = ST_LINEAR;
    end else begin
      sts_d = ST_TWO_ROOTS;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_q <= accept;
      end
      if (adv) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (s1_load && accept) begin
      mag_a_q     <= mag_a_d;
      mag_b_q     <= mag_b_d;
      mag_c_q     <= mag_c_d;
      sgn_diff1_q <= coef_a_i[W-1] ^ coef_c_i[W-1];
      sts1_q      <= sts_d;
      base1_q     <= base_d;
      den1_q      <= den_d;
    end
  end

  // Stage 2 payload: the two products
  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      bsq_q       <= mag_b_q * mag_b_q;
      ac_q        <= mag_a_q * mag_c_q;
      sgn_diff2_q <= sgn_diff1_q;
      sts2_q      <= sts1_q;
      base2_q     <= base1_q;
      den2_q      <= den1_q;
    end
  end

  // Discriminant and final classification
  always_comb begin
    bsq_x    = EXTW'(bsq_q);
    ac4_x    = {ac_q, 2'b00};
    disc_x   = '0;
    status_o = sts2_q;
    if (sts2_q == ST_TWO_ROOTS) begin
      if (sgn_diff2_q) begin
        disc_x = bsq_x + ac4_x;
      end else if (ac4_x <= bsq_x) begin
        disc_x = bsq_x - ac4_x;
      end else begin
        status_o = ST_COMPLEX;
      end
    end
  end

  assign disc_o = disc_x[DISCW-1:0];
  assign base_o = base2_q;
  assign den_o  = den2_q;

endmodule

`default_nettype wire

// ===== rtl/core/qrs_fifo.sv =====
// ----------------------------------------------------------------------------
// qrs_fifo
// Small register queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTRW-1:0]  wptr_q, wptr_d;
  logic [PTRW-1:0]  rptr_q, rptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTRW'(DEPTH - 1)) ? '0 : wptr_q + PTRW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTRW'(DEPTH - 1)) ? '0 : rptr_q + PTRW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/qrs_isqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_isqrt #(
  parameter int unsigned ROOT_WIDTH = 49,
  parameter int unsigned SIDE_WIDTH = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [2*ROOT_WIDTH-1:0] rad_i,
  input  logic [SIDE_WIDTH-1:0]   side_i,
  output logic                    valid_o,
  output logic [ROOT_WIDTH-1:0]   root_o,
  output logic [SIDE_WIDTH-1:0]   side_o
);

  localparam int unsigned RW   = ROOT_WIDTH;
  localparam int unsigned RADW = 2 * ROOT_WIDTH;
  localparam int unsigned REMW = ROOT_WIDTH + 2;
  localparam int unsigned TW   = ROOT_WIDTH + 4;

  logic                  v_q    [RW];
  logic [REMW-1:0]       rem_q  [RW];
  logic [RW-1:0]         root_q [RW];
  logic [RADW-1:0]       rad_q  [RW];
  logic [SIDE_WIDTH-1:0] side_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic                  v_in;
    logic [REMW-1:0]       rem_in;
    logic [RW-1:0]         root_in;
    logic [RADW-1:0]       rad_in;
    logic [SIDE_WIDTH-1:0] side_in;
    logic [TW-1:0]         t;
    logic [TW-1:0]         trial;
    logic                  fit;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
      assign side_in = side_q[j-1];
    end

    // Bring down two radicand bits, try root*4+1
    assign t     = {rem_in, rad_in[RADW-1 -: 2]};
    assign trial = TW'({root_in, 2'b01});
    assign fit   = (t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= fit ? REMW'(t - trial) : REMW'(t);
        root_q[j] <= {root_in[RW-2:0], fit};
        rad_q[j]  <= rad_in << 2;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

`default_nettype wire

// ===== rtl/core/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider with round-half-away-from-zero and
// saturation to the signed output width. Lanes share the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div import qrs_pkg::*; #(
  parameter int unsigned NUM_WIDTH  = 51,
  parameter int unsigned DEN_WIDTH  = 33,
  parameter int unsigned OUT_WIDTH  = 32,
  parameter int unsigned SIDE_WIDTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [NUM_LANES-1:0][NUM_WIDTH-1:0]  num_i,
  input  logic [DEN_WIDTH-1:0]                 den_i,
  input  logic [SIDE_WIDTH-1:0]                side_i,
  output logic                                 valid_o,
  output logic [NUM_LANES-1:0][OUT_WIDTH-1:0]  root_o,
  output logic [NUM_LANES-1:0]                 sat_o,
  output logic [SIDE_WIDTH-1:0]                side_o
);

  // Dividend 2|n|+|d| and divisor 2|d|
  localparam int unsigned NW = NUM_WIDTH + 1;
  localparam int unsigned DW = DEN_WIDTH + 1;

  logic [DEN_WIDTH-1:0]  mag_den;

  logic                  in_v_q;
  logic [DW-1:0]         in_d_q;
  logic [NW-1:0]         in_n_q   [NUM_LANES];
  logic                  in_neg_q [NUM_LANES];
  logic [SIDE_WIDTH-1:0] in_side_q;

  logic                  v_q    [NW];
  logic [DW-1:0]         d_q    [NW];
  logic [SIDE_WIDTH-1:0] side_q [NW];
  logic [NW-1:0]         qn_q   [NW][NUM_LANES];
  logic [DW-1:0]         rem_q  [NW][NUM_LANES];
  logic                  neg_q  [NW][NUM_LANES];

  logic                  out_v_q;
  logic [SIDE_WIDTH-1:0] out_side_q;

  assign mag_den = den_i[DEN_WIDTH-1] ? DEN_WIDTH'(-den_i) : den_i;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en_i) begin
      in_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_d_q    <= {mag_den, 1'b0};
      in_side_q <= side_i;
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_in
    logic [NUM_WIDTH-1:0] mag_num;

    assign mag_num = num_i[l][NUM_WIDTH-1] ? NUM_WIDTH'(-num_i[l]) : num_i[l];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        in_n_q[l]   <= {mag_num, 1'b0} + NW'(mag_den);
        in_neg_q[l] <= num_i[l][NUM_WIDTH-1] ^ den_i[DEN_WIDTH-1];
      end
    end
  end

  // Restoring stages, one quotient bit each
  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic                  v_in;
    logic [DW-1:0]         d_in;
    logic [SIDE_WIDTH-1:0] side_in;

    if (j == 0) begin : g_first
      assign v_in    = in_v_q;
      assign d_in    = in_d_q;
      assign side_in = in_side_q;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign d_in    = d_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[j]    <= d_in;
        side_q[j] <= side_in;
      end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [NW-1:0] qn_in;
      logic [DW-1:0] rem_in;
      logic          neg_in;
      logic [DW:0]   trial;
      logic          fit;

      if (j == 0) begin : g_first
        assign qn_in  = in_n_q[l];
        assign rem_in = '0;
        assign neg_in = in_neg_q[l];
      end else begin : g_next
        assign qn_in  = qn_q[j-1][l];
        assign rem_in = rem_q[j-1][l];
        assign neg_in = neg_q[j-1][l];
      end

      // Dividend bits shift out the top, quotient bits in at the bottom
      assign trial = {rem_in, qn_in[NW-1]};
      assign fit   = (trial >= {1'b0, d_in});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j][l] <= fit ? DW'(trial - {1'b0, d_in}) : DW'(trial);
          qn_q[j][l]  <= {qn_in[NW-2:0], fit};
          neg_q[j][l] <= neg_in;
        end
      end
    end
  end

  // Clamp and sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_side_q <= side_q[NW-1];
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_clamp
    logic [NW-1:0] lim;
    logic [NW-1:0] q;
    logic [NW-1:0] m;
    logic          sat;

    assign lim = NW'(1) << (OUT_WIDTH - 1);
    assign q   = qn_q[NW-1][l];

    always_comb begin
      sat = 1'b0;
      m   = q;
      if (neg_q[NW-1][l]) begin
        if (q > lim) begin
          sat = 1'b1;
          m   = lim;
        end
        m = NW'(0) - m;
      end else if (q >= lim) begin
        sat = 1'b1;
        m   = lim - NW'(1);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_o[l] <= m[OUT_WIDTH-1:0];
        sat_o[l]  <= sat;
      end
    end
  end

  assign valid_o = out_v_q;
  assign side_o  = out_side_q;

endmodule

`default_nettype wire

// ===== rtl/core/quadratic_root_solver_top.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c in signed fixed point, smaller root first.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive coef_a_i/coef_b_i/coef_c_i and raise push; a
//   transaction happens on a clock edge with push high and full low.
//   Result queue: while empty is low the oldest result sits on root_low_o,
//   root_high_o, root_status_o and saturated_o; pop high on such an edge
//   takes it. Exactly one result leaves per accepted coefficient set, in
//   order.
//   Throughput: one coefficient set per cycle while results are popped
//   as they appear. From accept to empty going low a set passes the front
//   stages, the queue, the one-bit-per-stage square root, the numerator
//   register, the one-bit-per-stage divider and the output register.
//   Stall: if the result is not taken, the back pipeline holds; the front
//   keeps filling a 4-entry queue and then raises full.
//   Reset: rst_ni low empties every stage and the queue at once; no
//   configuration and no state survive between items.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_top import qrs_pkg::*; #(
  parameter int unsigned COEF_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COEF_WIDTH-1:0] coef_a_i,
  input  logic signed [COEF_WIDTH-1:0] coef_b_i,
  input  logic signed [COEF_WIDTH-1:0] coef_c_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COEF_WIDTH-1:0] root_low_o,
  output logic signed [COEF_WIDTH-1:0] root_high_o,
  output logic        [1:0]            root_status_o,
  output logic                         saturated_o
);

  localparam int unsigned W      = COEF_WIDTH;
  localparam int unsigned DISCW  = 2 * COEF_WIDTH + 1;
  localparam int unsigned RW     = COEF_WIDTH + FRAC_BITS + 1;
  localparam int unsigned BASEW  = COEF_WIDTH + FRAC_BITS + 1;
  localparam int unsigned DENW   = COEF_WIDTH + 1;
  localparam int unsigned NUMW   = COEF_WIDTH + FRAC_BITS + 3;
  localparam int unsigned STSW   = $bits(status_e);
  localparam int unsigned SQSIDE = STSW + BASEW + DENW;
  localparam int unsigned QW     = STSW + BASEW + DENW + DISCW;

  // Front to queue
  logic                    f_push;
  logic                    q_full;
  status_e                 f_status;
  logic signed [BASEW-1:0] f_base;
  logic signed [DENW-1:0]  f_den;
  logic [DISCW-1:0]        f_disc;

  // Queue to back
  logic                    q_empty;
  logic                    q_pop;
  logic [QW-1:0]           q_wdata;
  logic [QW-1:0]           q_rdata;
  logic [2*RW-1:0]         rad;

  // Back pipeline
  logic                    ben;
  logic                    sq_valid;
  logic [RW-1:0]           sq_root;
  logic [SQSIDE-1:0]       sq_side;
  logic [STSW-1:0]         sq_status;
  logic signed [BASEW-1:0] sq_base;
  logic signed [DENW-1:0]  sq_den;
  logic signed [NUMW-1:0]  base_ext;
  logic signed [NUMW-1:0]  root_ext;

  logic                             prep_v_q;
  logic [NUM_LANES-1:0][NUMW-1:0]   prep_num_q;
  logic [DENW-1:0]                  prep_den_q;
  logic [STSW-1:0]                  prep_sts_q;

  logic                             d_valid;
  logic [NUM_LANES-1:0][W-1:0]      d_root;
  logic [NUM_LANES-1:0]             d_sat;
  logic [STSW-1:0]                  d_side;
  status_e                          d_status;
  logic signed [W-1:0]              r0;
  logic signed [W-1:0]              r1;

  logic                    out_v_q;
  logic signed [W-1:0]     low_q;
  logic signed [W-1:0]     high_q;
  status_e                 sts_q;
  logic                    sat_q;

  // Front: accept, square and classify
  qrs_front #(
    .COEF_WIDTH(COEF_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .coef_a_i(coef_a_i),
    .coef_b_i(coef_b_i),
    .coef_c_i(coef_c_i),
    .q_push_o(f_push),
    .q_full_i(q_full),
    .status_o(f_status),
    .base_o  (f_base),
    .den_o   (f_den),
    .disc_o  (f_disc)
  );

  assign q_wdata = {f_status, f_base, f_den, f_disc};

  // Queue between front and back
  qrs_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .full_o (q_full),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  // Back moves whenever the output register is free or being drained
  assign ben   = !out_v_q || pop;
  assign q_pop = ben && !q_empty;

  // Discriminant scaled by 2^(2F) for the square root
  assign rad = (2*RW)'(q_rdata[DISCW-1:0]) << (2 * FRAC_BITS);

  qrs_isqrt #(
    .ROOT_WIDTH(RW),
    .SIDE_WIDTH(SQSIDE)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (ben),
    .valid_i(!q_empty),
    .rad_i  (rad),
    .side_i (q_rdata[QW-1:DISCW]),
    .valid_o(sq_valid),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign sq_status = sq_side[SQSIDE-1 -: STSW];
  assign sq_base   = sq_side[DENW +: BASEW];
  assign sq_den    = sq_side[DENW-1:0];
  assign base_ext  = NUMW'(sq_base);
  assign root_ext  = NUMW'($signed({1'b0, sq_root}));

  // Numerators -b*2^F -/+ sqrt (linear: -c*2^F, and the root is zero)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (ben) begin
      prep_v_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben) begin
      prep_num_q[0] <= base_ext - root_ext;
      prep_num_q[1] <= base_ext + root_ext;
      prep_den_q    <= sq_den;
      prep_sts_q    <= sq_status;
    end
  end

  qrs_div #(
    .NUM_WIDTH (NUMW),
    .DEN_WIDTH (DENW),
    .OUT_WIDTH (W),
    .SIDE_WIDTH(STSW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (ben),
    .valid_i(prep_v_q),
    .num_i  (prep_num_q),
    .den_i  (prep_den_q),
    .side_i (prep_sts_q),
    .valid_o(d_valid),
    .root_o (d_root),
    .sat_o  (d_sat),
    .side_o (d_side)
  );

  assign d_status = status_e'(d_side);
  assign r0       = $signed(d_root[0]);
  assign r1       = $signed(d_root[1]);

  // Output register: order the roots, blank the no-root cases
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ben) begin
      out_v_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben && d_valid) begin
      sts_q <= d_status;
      if (d_status == ST_INDET || d_status == ST_COMPLEX) begin
        low_q  <= '0;
        high_q <= '0;
        sat_q  <= 1'b0;
      end else begin
        low_q  <= (r0 < r1) ? r0 : r1;
        high_q <= (r0 < r1) ? r1 : r0;
        sat_q  <= d_sat[0] | d_sat[1];
      end
    end
  end

  assign empty         = !out_v_q;
  assign root_low_o    = low_q;
  assign root_high_o   = high_q;
  assign root_status_o = sts_q;
  assign saturated_o   = sat_q;

endmodule

`default_nettype wire

// ===== rtl/core/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks on the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_checker import qrs_pkg::*; #(
  parameter int unsigned COEF_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         push,
  input logic                         full,
  input logic signed [COEF_WIDTH-1:0] coef_a_i,
  input logic signed [COEF_WIDTH-1:0] coef_b_i,
  input logic signed [COEF_WIDTH-1:0] coef_c_i,
  input logic                         empty,
  input logic                         pop,
  input logic signed [COEF_WIDTH-1:0] root_low_o,
  input logic signed [COEF_WIDTH-1:0] root_high_o,
  input logic        [1:0]            root_status_o,
  input logic                         saturated_o
);

  // Roots leave in order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> root_low_o <= root_high_o)
    else $error("root_low above root_high");

  // No-root cases carry zeros and no saturation
  a_noroot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (root_status_o == ST_INDET || root_status_o == ST_COMPLEX))
    |-> (root_low_o == '0 && root_high_o == '0 && !saturated_o))
    else $error("no-root result carries data");

  // A linear equation has one root, repeated
  a_linear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && root_status_o == ST_LINEAR) |-> root_low_o == root_high_o)
    else $error("linear result has two different roots");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(root_low_o) && $stable(root_high_o)
                          && $stable(root_status_o) && $stable(saturated_o)))
    else $error("waiting result changed");

endmodule

bind quadratic_root_solver_top qrs_checker #(.COEF_WIDTH(COEF_WIDTH)) u_qrs_checker (.*);

`default_nettype wire
